// ===== rtl/qpht_pkg.sv =====
// ----------------------------------------------------------------------------
// qpht_pkg: shared constants for the quadratic-probe hash table
// Table geometry, command and status codes, and widths derived from them.
// ----------------------------------------------------------------------------
package qpht_pkg;

  localparam int TABLE_SLOTS = 31;
  localparam int KEY_BYTES   = 8;

  localparam int SLOT_W     = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int CNT_W      = $clog2(TABLE_SLOTS + 1);
  localparam int BYTE_CNT_W = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
  localparam int KEY_W      = 64;
  localparam int VALUE_W    = 64;

  // command codes
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_SEARCH = 2'd1;
  localparam logic [1:0] CMD_DELETE = 2'd2;

  // status codes
  localparam logic [1:0] STATUS_DONE    = 2'd0;
  localparam logic [1:0] STATUS_PRESENT = 2'd1;
  localparam logic [1:0] STATUS_FULL    = 2'd2;
  localparam logic [1:0] STATUS_MISSING = 2'd3;

  // operand pair for the shared modular adder
  typedef struct packed {
    logic [SLOT_W-1:0] a;
    logic [SLOT_W-1:0] b;
  } madd_req_t;

endpackage

// ===== rtl/qpht_ram.sv =====
// ----------------------------------------------------------------------------
// qpht_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module qpht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/qpht_madd.sv =====
// ----------------------------------------------------------------------------
// qpht_madd: modular adder
// Sum of two residues modulo TABLE_SLOTS with one compare and subtract.
// ----------------------------------------------------------------------------
module qpht_madd
  import qpht_pkg::*;
(
  input  madd_req_t         req,
  output logic [SLOT_W-1:0] sum
);

  logic [SLOT_W:0] raw;

  assign raw = {1'b0, req.a} + {1'b0, req.b};
  // both operands stay below the modulus, so one subtract is enough
  assign sum = (raw >= (SLOT_W + 1)'(TABLE_SLOTS))
             ? SLOT_W'(raw - (SLOT_W + 1)'(TABLE_SLOTS))
             : SLOT_W'(raw);

endmodule

// ===== rtl/quadratic_probe_hash_table.sv =====
// ----------------------------------------------------------------------------
// quadratic_probe_hash_table: open-addressing key/value table
// Insert, search and delete on a table probed with quadratic steps.
// ----------------------------------------------------------------------------
// Each request carries an operation in s_axis_tuser and a key and value in
// s_axis_tdata; each request returns exactly one response on m_axis. The
// block works on one request at a time and drops s_axis_tready after the
// accept cycle until the response is loaded into the output register. A
// request passes an accept state, hashing (one key byte per cycle through
// the shared modular adder), probing (one slot read per cycle from the
// key/value RAM) and a response state that waits for the output register.
// An unused operation code skips hashing and probing and answers not found.
// Used and tombstone flags sit in flip-flops that reset clears, so the
// table is empty right out of reset with no clearing pass.
// ----------------------------------------------------------------------------
module quadratic_probe_hash_table
  import qpht_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,  // key_bytes[63:0], value_word[127:64]
  input  logic [1:0]   s_axis_tuser,  // cmd[1:0]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [79:0]  m_axis_tdata,  // slot_index[4:0], found_value[68:5],
                                      // live_keys[73:69], zero above
  output logic [1:0]   m_axis_tuser   // status[1:0]
);

  // sequencer states
  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_HASH   = 2'd1;
  localparam logic [1:0] S_PROBE  = 2'd2;
  localparam logic [1:0] S_RESULT = 2'd3;

  logic [1:0] state;

  // request registers
  logic [1:0]             cmd;
  logic [VALUE_W-1:0]     value;
  logic [8*KEY_BYTES-1:0] key_sh;    // raw key, shifted one byte per cycle
  logic [8*KEY_BYTES-1:0] knorm;     // key cut at its first zero byte
  logic                   ended;
  logic [BYTE_CNT_W-1:0]  bcnt;

  // probe registers
  logic [SLOT_W-1:0] sum;
  logic [SLOT_W-1:0] home;
  logic [SLOT_W-1:0] idx;
  logic [SLOT_W-1:0] idx_next;
  logic [SLOT_W-1:0] step;           // (2i - 1) mod TABLE_SLOTS
  logic [SLOT_W:0]   step_raw;

  // table flags and count
  logic [TABLE_SLOTS-1:0] used;
  logic [TABLE_SLOTS-1:0] tomb;
  logic [CNT_W-1:0]       live;

  // pending response
  logic [1:0]         res_status;
  logic [SLOT_W-1:0]  res_slot;
  logic [VALUE_W-1:0] res_value;

  // output register
  logic [1:0]         out_status;
  logic [4:0]         out_slot;
  logic [VALUE_W-1:0] out_value;
  logic [4:0]         out_live;

  logic                s_accept;
  logic [7:0]          byte_cur;
  logic                byte_ok;
  logic [31:0]         byte_rem;
  logic [SLOT_W-1:0]   byte_mod;
  logic [SLOT_W-1:0]   sum_next;
  logic                hash_last;
  logic [KEY_W-1:0]    key64;
  madd_req_t           madd_req;
  logic [SLOT_W-1:0]   madd_sum;

  // probe decisions for the slot under the read port
  logic                slot_empty;
  logic                slot_hit;
  logic                wrap;
  logic                probe_stop;
  logic                do_insert;

  logic                   ram_we;
  logic [KEY_W+VALUE_W-1:0] ram_wdata;
  logic [KEY_W+VALUE_W-1:0] ram_rdata;
  logic                   out_free;

  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == S_IDLE);
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  // hash step: fold one key byte into the home residue
  assign byte_cur  = key_sh[7:0];
  assign byte_ok   = !ended && (byte_cur != 8'h00);

  // reduce the key byte below the table size: shifted compare and subtract
  always_comb begin
    byte_rem = {24'd0, byte_cur};
    for (int k = 7; k >= 0; k--) begin
      if (byte_rem >= 32'(TABLE_SLOTS << k)) begin
        byte_rem = byte_rem - 32'(TABLE_SLOTS << k);
      end
    end
  end

  assign byte_mod  = SLOT_W'(byte_rem);
  assign hash_last = (bcnt == BYTE_CNT_W'(KEY_BYTES - 1));
  assign sum_next  = byte_ok ? madd_sum : sum;
  assign key64     = KEY_W'(knorm);

  // share the modular adder: key bytes while hashing, probe steps later
  always_comb begin
    if (state == S_PROBE) begin
      madd_req.a = idx;
      madd_req.b = step;
    end else begin
      madd_req.a = sum;
      madd_req.b = byte_mod;
    end
  end

  qpht_madd u_madd (
    .req (madd_req),
    .sum (madd_sum)
  );

  // next odd step, reduced modulo the table size
  assign step_raw = {1'b0, step} + (SLOT_W + 1)'(2);

  // read data always belongs to the slot held in idx
  assign slot_empty = !used[idx];
  assign slot_hit   = used[idx] && !tomb[idx] && (ram_rdata[KEY_W-1:0] == key64);
  assign wrap       = !slot_empty && !slot_hit && (madd_sum == home);
  assign probe_stop = slot_empty || slot_hit || wrap;
  assign do_insert  = (state == S_PROBE) && (cmd == CMD_INSERT) && slot_empty;

  // read address is the next value of idx so the registered read lines up
  always_comb begin
    idx_next = idx;
    unique case (state)
      S_HASH: begin
        if (hash_last) begin
          idx_next = sum_next;
        end
      end
      S_PROBE: begin
        if (!probe_stop) begin
          idx_next = madd_sum;
        end
      end
      default: begin
        idx_next = idx;
      end
    endcase
  end

  assign ram_we    = do_insert;
  assign ram_wdata = {value, key64};

  qpht_ram #(
    .WIDTH (KEY_W + VALUE_W),
    .DEPTH (TABLE_SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx),
    .wdata (ram_wdata),
    .raddr (idx_next),
    .rdata (ram_rdata)
  );

  // sequencer and table flags
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      used          <= '0;
      tomb          <= '0;
      live          <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      // raise valid as the response loads, drop it once the sink takes it
      if (state == S_RESULT && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_accept) begin
            if (s_axis_tuser == CMD_INSERT || s_axis_tuser == CMD_SEARCH ||
                s_axis_tuser == CMD_DELETE) begin
              state <= S_HASH;
            end else begin
              state <= S_RESULT;
            end
          end
        end
        S_HASH: begin
          if (hash_last) begin
            state <= S_PROBE;
          end
        end
        S_PROBE: begin
          if (probe_stop) begin
            state <= S_RESULT;
          end
          if (do_insert) begin
            used[idx] <= 1'b1;
            tomb[idx] <= 1'b0;
            live      <= live + CNT_W'(1);
          end else if (slot_hit && cmd == CMD_DELETE) begin
            tomb[idx] <= 1'b1;
            live      <= live - CNT_W'(1);
          end
        end
        S_RESULT: begin
          // hold the response until the output register frees up
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    idx <= idx_next;
    unique case (state)
      S_IDLE: begin
        if (s_accept) begin
          cmd        <= s_axis_tuser;
          key_sh     <= s_axis_tdata[8*KEY_BYTES-1:0];
          value      <= s_axis_tdata[127:64];
          knorm      <= '0;
          ended      <= 1'b0;
          bcnt       <= '0;
          sum        <= '0;
          res_status <= STATUS_MISSING;
          res_slot   <= '0;
          res_value  <= '0;
        end
      end
      S_HASH: begin
        key_sh             <= key_sh >> 8;
        knorm[bcnt*8 +: 8] <= byte_ok ? byte_cur : 8'h00;
        ended              <= ended || (byte_cur == 8'h00);
        bcnt               <= bcnt + BYTE_CNT_W'(1);
        sum                <= sum_next;
        if (hash_last) begin
          home <= sum_next;
          step <= SLOT_W'(1);
        end
      end
      S_PROBE: begin
        // advance by the next odd number: i*i grows by 2i - 1
        step <= (step_raw >= (SLOT_W + 1)'(TABLE_SLOTS))
              ? SLOT_W'(step_raw - (SLOT_W + 1)'(TABLE_SLOTS))
              : SLOT_W'(step_raw);
        if (slot_hit) begin
          if (cmd == CMD_INSERT) begin
            res_status <= STATUS_PRESENT;
          end else if (cmd == CMD_SEARCH) begin
            res_status <= STATUS_DONE;
            res_slot   <= idx;
            res_value  <= ram_rdata[KEY_W+VALUE_W-1:KEY_W];
          end else begin
            res_status <= STATUS_DONE;
            res_slot   <= idx;
          end
        end else if (slot_empty) begin
          if (cmd == CMD_INSERT) begin
            res_status <= STATUS_DONE;
            res_slot   <= idx;
          end
        end else if (wrap && cmd == CMD_INSERT) begin
          res_status <= STATUS_FULL;
        end
      end
      S_RESULT: begin
        if (out_free) begin
          out_status <= res_status;
          out_slot   <= 5'(res_slot);
          out_value  <= res_value;
          out_live   <= 5'(live);
        end
      end
      default: begin
        cmd <= cmd;
      end
    endcase
  end

  assign m_axis_tuser = out_status;
  assign m_axis_tdata = {6'd0, out_live, out_value, out_slot};

  // a failed request never reports a slot or a value
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser != STATUS_DONE) |->
      (m_axis_tdata[4:0] == 5'd0) && (m_axis_tdata[68:5] == 64'd0))
    else $error("failed request reports a slot or value");

  // the live count never exceeds the number of slots
  assert property (@(posedge clk) disable iff (rst)
    live <= CNT_W'(TABLE_SLOTS))
    else $error("live count beyond table size");

  // probe index and step stay valid residues
  assert property (@(posedge clk) disable iff (rst)
    (state == S_PROBE) |->
      (idx < SLOT_W'(TABLE_SLOTS)) && (step < SLOT_W'(TABLE_SLOTS)))
    else $error("probe index or step out of range");

  // an accepted request blocks further requests on the next cycle
  assert property (@(posedge clk) disable iff (rst)
    s_accept |=> !s_axis_tready)
    else $error("ready while a request is in progress");

  // an insert only writes a slot that was never used
  assert property (@(posedge clk) disable iff (rst)
    ram_we |-> !used[idx])
    else $error("insert over a used slot");

endmodule
